### design/ars_pkg.sv
package ars_pkg;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MDD,
    ST_MFF,
    ST_MUU,
    ST_MFD,
    ST_CHK,
    ST_DIV1,
    ST_H0,
    ST_H1,
    ST_H2,
    ST_H3,
    ST_SQW,
    ST_R1,
    ST_R2,
    ST_R3,
    ST_R4,
    ST_DIV2,
    ST_FIN
  } state_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_UPPER = 3'd0,
    CFG_FORE  = 3'd1,
    CFG_PAN   = 3'd2,
    CFG_BIAS  = 3'd3,
    CFG_MINR  = 3'd4
  } cfg_idx_t;

  localparam int DIV_STEPS = 17;

  // Divider start request
  typedef struct packed {
    logic        start;
    logic [22:0] rem_init;
    logic [16:0] dividend;
    logic [22:0] divisor;
  } div_req_t;

  // Divider status
  typedef struct packed {
    logic        busy;
    logic [16:0] quot;
  } div_rsp_t;

endpackage

### design/arm_reach_step_and_servo_solver.sv
// Two-link arm reach solver: base stepper delta and elbow servo value.
// Input channel (in_valid/in_ready) takes one grab request: distance_mm and
// pan_servo. The result channel (out_valid/out_ready) returns one result per
// request: step_delta, step_fail, elbow_target, elbow_fail, any_fail.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; write it only while no request is in flight. Unknown indexes are
// dropped.
// For a valid geometry a request runs a restoring divider for the cosine, a
// square root overlapped with the polynomial, and one shared 25x18 multiplier
// used in sequence; the final divide by 2304 is done as a reciprocal multiply.
// A rejected geometry skips the divider, the square root and the polynomial.
// One request at a time: in_ready is high only in the idle state, so a new
// request is not accepted until the previous result has gone to the output
// register.
// When out_ready is low the finished result waits in the sequencer and the
// output register holds; the next request is not accepted until it drains.
// Reset clears the stored step position to 0 and loads the default
// configuration (350, 350, 164, 220, 100).
module arm_reach_step_and_servo_solver #(
  parameter int STEP_LIMIT = 800
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [10:0]       in_distance_mm,
  input  logic [7:0]        in_pan_servo,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [10:0] out_step_delta,
  output logic              out_step_fail,
  output logic [7:0]        out_elbow_target,
  output logic              out_elbow_fail,
  output logic              out_any_fail,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [10:0]       cfg_data
);

  localparam logic [9:0] LIMIT = 10'(STEP_LIMIT);

  ars_pkg::state_t state_r, state_nxt;

  // Configuration
  logic [9:0]  upper_r, fore_r;
  logic [7:0]  pan_c_r;
  logic [8:0]  bias_r;
  logic [10:0] minr_r;

  // Request and working registers
  logic [10:0]        d_r, d_nxt;
  logic [7:0]         pan_r, pan_nxt;
  logic signed [24:0] acc_r, acc_nxt;
  logic [16:0]        x_r, x_nxt;
  logic [16:0]        p_r, p_nxt;
  logic [14:0]        a_r, a_nxt;
  logic               neg_r, neg_nxt;
  logic               nneg_r, nneg_nxt;
  logic               geom_r, geom_nxt;
  logic [9:0]         last_r, last_nxt;

  // Shared multiplier
  logic signed [24:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [42:0] prod_r;

  // Output register
  logic               ov_r, ov_nxt;
  logic signed [10:0] o_delta_r, o_delta_nxt;
  logic               o_sfail_r, o_sfail_nxt;
  logic [7:0]         o_tgt_r, o_tgt_nxt;
  logic               o_efail_r, o_efail_nxt;

  ars_pkg::div_req_t div_req;
  ars_pkg::div_rsp_t div_rsp;
  logic              sq_start, sq_busy;
  logic [32:0]       sq_rad;
  logic [16:0]       sq_root;

  // Scratch
  logic [23:0]        den;
  logic [24:0]        mag;
  logic signed [26:0] hq;
  logic [17:0]        r_mag;
  logic [17:0]        r_fix;
  logic [14:0]        a_new;
  logic signed [24:0] n_sum;
  logic [24:0]        n_mag;
  logic [16:0]        j2;
  logic signed [18:0] ediff;
  logic               e_ok, s_ok;
  logic [16:0]        q;

  // Divide by 65536, rounding toward zero
  function automatic logic signed [26:0] tz16(input logic signed [42:0] v);
    logic signed [42:0] t;
    t = v + (v[42] ? 43'sd65535 : 43'sd0);
    return 27'(t >>> 16);
  endfunction

  ars_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  ars_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sq_start),
    .radicand(sq_rad),
    .busy    (sq_busy),
    .root    (sq_root)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ars_pkg::ST_IDLE);

  // Sequencer: next state, working registers, multiplier operands, unit starts, results
  always_comb begin
    state_nxt = state_r;
    d_nxt     = d_r;
    pan_nxt   = pan_r;
    acc_nxt   = acc_r;
    x_nxt     = x_r;
    p_nxt     = p_r;
    a_nxt     = a_r;
    neg_nxt   = neg_r;
    nneg_nxt  = nneg_r;
    geom_nxt  = geom_r;
    last_nxt  = last_r;
    mul_a     = '0;
    mul_b     = '0;
    div_req   = '0;
    sq_start  = 1'b0;
    sq_rad    = 33'(({1'b0, 17'h10000} - {1'b0, div_rsp.quot})) << 16;
    ov_nxt      = ov_r && !out_ready;
    o_delta_nxt = o_delta_r;
    o_sfail_nxt = o_sfail_r;
    o_tgt_nxt   = o_tgt_r;
    o_efail_nxt = o_efail_r;

    den   = {prod_r[22:0], 1'b0};
    mag   = acc_r[24] ? 25'(-acc_r) : 25'(acc_r);
    hq    = tz16(prod_r);
    r_mag = prod_r[33:16];
    r_fix = neg_r ? (18'd205887 - r_mag) : r_mag;
    a_new = prod_r[22:8];
    n_sum = acc_r + 25'(prod_r);
    n_mag = n_sum[24] ? 25'(-n_sum) : 25'(n_sum);
    // Base position magnitude, held in x_r once the divide by 2304 is done
    q     = x_r;

    // Base path check
    s_ok = geom_r && (!nneg_r || q == 17'd0) && (q <= {7'd0, LIMIT});
    // Elbow path check
    j2    = 17'({2'b0, a_r} + 17'd4864) << 1;
    ediff = 19'({bias_r, 8'd0}) - 19'(j2);
    e_ok  = geom_r && ({1'b0, d_r} <= ({2'b0, upper_r} + {2'b0, fore_r}))
            && (d_r >= minr_r) && (j2 <= 17'd40960) && (ediff > -19'sd256)
            && (ediff[18] || (ediff[18:8] <= 11'd250));

    case (state_r)
      ars_pkg::ST_IDLE: begin
        if (in_valid) begin
          d_nxt     = in_distance_mm;
          pan_nxt   = in_pan_servo;
          state_nxt = ars_pkg::ST_MDD;
        end
      end
      ars_pkg::ST_MDD: begin
        mul_a     = 25'(d_r);
        mul_b     = 18'(d_r);
        state_nxt = ars_pkg::ST_MFF;
      end
      ars_pkg::ST_MFF: begin
        acc_nxt   = 25'(prod_r);
        mul_a     = 25'(fore_r);
        mul_b     = 18'(fore_r);
        state_nxt = ars_pkg::ST_MUU;
      end
      ars_pkg::ST_MUU: begin
        acc_nxt   = acc_r + 25'(prod_r);
        mul_a     = 25'(upper_r);
        mul_b     = 18'(upper_r);
        state_nxt = ars_pkg::ST_MFD;
      end
      ars_pkg::ST_MFD: begin
        acc_nxt   = acc_r - 25'(prod_r);
        mul_a     = 25'(fore_r);
        mul_b     = 18'(d_r);
        state_nxt = ars_pkg::ST_CHK;
      end
      ars_pkg::ST_CHK: begin
        neg_nxt  = acc_r[24];
        geom_nxt = (den != 24'd0) && ({1'b0, den} >= mag);
        if ((den != 24'd0) && ({1'b0, den} >= mag)) begin
          div_req.start    = 1'b1;
          div_req.rem_init = mag[23:1];
          div_req.dividend = {mag[0], 16'd0};
          div_req.divisor  = den[22:0];
          state_nxt        = ars_pkg::ST_DIV1;
        end else begin
          state_nxt = ars_pkg::ST_FIN;
        end
      end
      ars_pkg::ST_DIV1: begin
        if (!div_rsp.busy) begin
          x_nxt     = div_rsp.quot;
          sq_start  = 1'b1;
          state_nxt = ars_pkg::ST_H0;
        end
      end
      ars_pkg::ST_H0: begin
        mul_a     = -25'sd1227;
        mul_b     = 18'(x_r);
        state_nxt = ars_pkg::ST_H1;
      end
      ars_pkg::ST_H1: begin
        mul_a     = 25'(hq + 27'sd4867);
        mul_b     = 18'(x_r);
        state_nxt = ars_pkg::ST_H2;
      end
      ars_pkg::ST_H2: begin
        mul_a     = 25'(hq - 27'sd13901);
        mul_b     = 18'(x_r);
        state_nxt = ars_pkg::ST_H3;
      end
      ars_pkg::ST_H3: begin
        p_nxt     = 17'(hq + 27'sd102939);
        state_nxt = ars_pkg::ST_SQW;
      end
      ars_pkg::ST_SQW: begin
        if (!sq_busy) begin
          mul_a     = 25'(p_r);
          mul_b     = 18'(sq_root);
          state_nxt = ars_pkg::ST_R1;
        end
      end
      ars_pkg::ST_R1: begin
        mul_a     = 25'(r_fix);
        mul_b     = 18'sd40;
        state_nxt = ars_pkg::ST_R2;
      end
      ars_pkg::ST_R2: begin
        a_nxt     = a_new;
        mul_a     = 25'(a_new) + 25'sd28416;
        mul_b     = 18'sd40;
        state_nxt = ars_pkg::ST_R3;
      end
      ars_pkg::ST_R3: begin
        acc_nxt   = 25'(prod_r);
        mul_a     = 25'(pan_r) - 25'(pan_c_r);
        mul_b     = 18'sd9216;
        state_nxt = ars_pkg::ST_R4;
      end
      ars_pkg::ST_R4: begin
        // |sum| / 2304 = floor((|sum| >> 8) / 9); divide by 9 as a multiply by
        // ceil(2^19 / 9), exact for operands below 74898
        nneg_nxt  = n_sum[24];
        mul_a     = 25'(n_mag[24:8]);
        mul_b     = 18'sd58255;
        state_nxt = ars_pkg::ST_DIV2;
      end
      ars_pkg::ST_DIV2: begin
        x_nxt     = prod_r[35:19];
        state_nxt = ars_pkg::ST_FIN;
      end
      ars_pkg::ST_FIN: begin
        if (!ov_r || out_ready) begin
          ov_nxt      = 1'b1;
          o_sfail_nxt = !s_ok;
          o_efail_nxt = !e_ok;
          o_delta_nxt = s_ok ? (11'({1'b0, q[9:0]}) - 11'({1'b0, last_r})) : 11'sd0;
          o_tgt_nxt   = (e_ok && !ediff[18]) ? ediff[15:8] : 8'd0;
          if (s_ok) begin
            last_nxt = q[9:0];
          end
          state_nxt = ars_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ars_pkg::ST_IDLE;
      end
    endcase
  end

  // Control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ars_pkg::ST_IDLE;
      ov_r    <= 1'b0;
      last_r  <= '0;
      upper_r <= 10'd350;
      fore_r  <= 10'd350;
      pan_c_r <= 8'd164;
      bias_r  <= 9'd220;
      minr_r  <= 11'd100;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      last_r  <= last_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          ars_pkg::CFG_UPPER: upper_r <= cfg_data[9:0];
          ars_pkg::CFG_FORE:  fore_r  <= cfg_data[9:0];
          ars_pkg::CFG_PAN:   pan_c_r <= cfg_data[7:0];
          ars_pkg::CFG_BIAS:  bias_r  <= cfg_data[8:0];
          ars_pkg::CFG_MINR:  minr_r  <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    d_r       <= d_nxt;
    pan_r     <= pan_nxt;
    acc_r     <= acc_nxt;
    x_r       <= x_nxt;
    p_r       <= p_nxt;
    a_r       <= a_nxt;
    neg_r     <= neg_nxt;
    nneg_r    <= nneg_nxt;
    geom_r    <= geom_nxt;
    prod_r    <= 43'(mul_a * mul_b);
    o_delta_r <= o_delta_nxt;
    o_sfail_r <= o_sfail_nxt;
    o_tgt_r   <= o_tgt_nxt;
    o_efail_r <= o_efail_nxt;
  end

  assign out_valid        = ov_r;
  assign out_step_delta   = o_delta_r;
  assign out_step_fail    = o_sfail_r;
  assign out_elbow_target = o_tgt_r;
  assign out_elbow_fail   = o_efail_r;
  assign out_any_fail     = o_sfail_r | o_efail_r;

endmodule

### design/ars_div.sv
module ars_div (
  input  logic              clk,
  input  logic              rst_n,
  input  ars_pkg::div_req_t req,
  output ars_pkg::div_rsp_t rsp
);

  logic [23:0] rem_r, rem_nxt;
  logic [16:0] sr_r, sr_nxt;
  logic [16:0] q_r, q_nxt;
  logic [22:0] div_r, div_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [23:0] trial;
  logic        ge;

  // One restoring step per cycle
  always_comb begin
    trial    = {rem_r[22:0], sr_r[16]};
    ge       = trial >= {1'b0, div_r};
    rem_nxt  = rem_r;
    sr_nxt   = sr_r;
    q_nxt    = q_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (req.start) begin
      rem_nxt  = {1'b0, req.rem_init};
      sr_nxt   = req.dividend;
      q_nxt    = '0;
      div_nxt  = req.divisor;
      cnt_nxt  = 5'(ars_pkg::DIV_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? (trial - {1'b0, div_r}) : trial;
      sr_nxt  = {sr_r[15:0], 1'b0};
      q_nxt   = {q_r[15:0], ge};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    sr_r  <= sr_nxt;
    q_r   <= q_nxt;
    div_r <= div_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.quot = q_r;

endmodule

### design/ars_sqrt.sv
module ars_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [32:0] radicand,
  output logic        busy,
  output logic [16:0] root
);

  logic [33:0] v_r, v_nxt;
  logic [33:0] res_r, res_nxt;
  logic [33:0] bit_r, bit_nxt;
  logic        busy_r, busy_nxt;
  logic [33:0] trial;

  // Digit-by-digit root, two radicand bits per cycle
  always_comb begin
    trial    = res_r + bit_r;
    v_nxt    = v_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    if (start) begin
      v_nxt    = {1'b0, radicand};
      res_nxt  = '0;
      bit_nxt  = 34'd1 << 32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_nxt   = v_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r == 34'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    v_r   <= v_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign busy = busy_r;
  assign root = res_r[16:0];

endmodule

### design/ars_chk.sv
module ars_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [10:0] out_step_delta,
  input logic              out_step_fail,
  input logic [7:0]        out_elbow_target,
  input logic              out_elbow_fail,
  input logic              out_any_fail
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // One request in flight: not ready right after an accept
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request accepted while busy");

  // Failed base path carries no step
  a_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_step_fail |-> out_step_delta == 11'sd0)
    else $error("step delta nonzero on failure");

  // Failed elbow path carries no target
  a_elbow_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_elbow_fail |-> out_elbow_target == 8'd0)
    else $error("elbow target nonzero on failure");

  // Combined flag follows the two path flags
  a_any: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_any_fail == (out_step_fail || out_elbow_fail))
    else $error("any_fail mismatch");

endmodule

bind arm_reach_step_and_servo_solver ars_chk u_ars_chk (.*);
